[rtl/lil_pkg.sv]
// shared types and constants for the line index offset locator
// no dependencies; imported by lil_table users and the top level

package lil_pkg;

    // operation codes carried by the input beat
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_LOCATE = 2'd1,
        OP_SPAN   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_LOC  = 3'd1,
        S_SP1  = 3'd2,
        S_SP2  = 3'd3,
        S_LEN  = 3'd4,
        S_OUT  = 3'd5
    } t_state;

    localparam logic [7:0] NL_BYTE = 8'h0A;
    localparam logic [7:0] CR_BYTE = 8'h0D;

    // fixed field widths
    localparam int OFF_W  = 16;
    localparam int QLN_W  = 13;
    localparam int LNUM_W = 13;
    localparam int POS_W  = 17;

endpackage

[rtl/line_index_offset_locator.sv]
// top level of the line index offset locator: sequencer, counters and result register
// depends on lil_pkg and lil_table
//
//  channel   direction  handshake           payload
//  -------   ---------  ------------------  ----------------------------------------------
//  input     in         i_valid / o_stall   i_operation, i_byte_value, i_query_offset,
//                                           i_query_line
//  result    out        o_valid / i_stall   o_line_number, o_column_number, o_span_start,
//                                           o_span_length, o_span_invalid, o_table_full
//
// append and clear give no result and leave the sequencer idle
// locate is a binary search over the recorded line starts, one memory read per probe;
//   the probes run one after another, as the line start memory has a single read port
// line span: S_SP1, S_SP2 unless last line, S_LEN, S_OUT; an invalid line: S_OUT only
// one beat is worked on at a time; o_stall is high while a beat is in progress
// reset is synchronous, active low; no clearing pass: entry 0 reads as zero by design
// a finished result waits in the output register while the next beat is accepted

module line_index_offset_locator import lil_pkg::*; #(
    parameter int MAX_LINES = 4096,
    parameter int MAX_BYTES = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_operation,
    input  logic [7:0]        i_byte_value,
    input  logic [OFF_W-1:0]  i_query_offset,
    input  logic [QLN_W-1:0]  i_query_line,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [LNUM_W-1:0] o_line_number,
    output logic [POS_W-1:0]  o_column_number,
    output logic [POS_W-1:0]  o_span_start,
    output logic [POS_W-1:0]  o_span_length,
    output logic              o_span_invalid,
    output logic              o_table_full
);

    localparam int ADDR_W = $clog2(MAX_LINES);
    localparam int LINE_W = $clog2(MAX_LINES + 1);
    localparam int BYTE_W = $clog2(MAX_BYTES + 1);
    // comparison widths cover both the table values and the query fields
    localparam int CMP_W  = (BYTE_W > OFF_W) ? BYTE_W : OFF_W;
    localparam int QCMP_W = (LINE_W > QLN_W) ? LINE_W : QLN_W;

    // control state
    t_state              r_state, n_state;
    logic [LINE_W-1:0]   r_lines, n_lines;
    logic [BYTE_W-1:0]   r_bytes, n_bytes;
    logic                r_prev_cr, n_prev_cr;
    logic                r_ovf, n_ovf;
    logic                r_out_valid, n_out_valid;

    // working registers of the search and span sequences
    logic [LINE_W-1:0]   r_lo, n_lo;
    logic [LINE_W-1:0]   r_hi, n_hi;
    logic [ADDR_W-1:0]   r_mid, n_mid;
    logic [BYTE_W-1:0]   r_lo_start, n_lo_start;
    logic [OFF_W-1:0]    r_off, n_off;
    logic [BYTE_W-1:0]   r_start, n_start;
    logic [BYTE_W-1:0]   r_end, n_end;
    logic                r_cr, n_cr;

    // pending result
    logic [LNUM_W-1:0]   r_res_line, n_res_line;
    logic [POS_W-1:0]    r_res_col, n_res_col;
    logic [POS_W-1:0]    r_res_start, n_res_start;
    logic [POS_W-1:0]    r_res_len, n_res_len;
    logic                r_res_inv, n_res_inv;

    // output register
    logic [LNUM_W-1:0]   r_o_line;
    logic [POS_W-1:0]    r_o_col;
    logic [POS_W-1:0]    r_o_start;
    logic [POS_W-1:0]    r_o_len;
    logic                r_o_inv;
    logic                r_o_full;
    logic                out_load;

    // memory port signals
    logic                mem_we;
    logic [ADDR_W-1:0]   rd_addr;
    logic [BYTE_W-1:0]   start_rdata;
    logic                cr_rdata;

    // search step helpers
    logic                probe_le;
    logic [LINE_W-1:0]   lo_nx, hi_nx;
    logic [BYTE_W-1:0]   start_nx;
    logic [ADDR_W-1:0]   mid_nx;
    logic                accept;
    logic                span_bad;

    lil_table #(
        .DEPTH  (MAX_LINES),
        .DATA_W (BYTE_W)
    ) u_table (
        .i_clk         (i_clk),
        .i_we          (mem_we),
        .i_start_waddr (r_lines[ADDR_W-1:0]),
        .i_start_wdata (r_bytes + BYTE_W'(1)),
        .i_cr_waddr    (ADDR_W'(r_lines - LINE_W'(1))),
        .i_cr_wdata    (r_prev_cr),
        .i_rd_addr     (rd_addr),
        .o_start_rdata (start_rdata),
        .o_cr_rdata    (cr_rdata)
    );

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);

    // one probe of the binary search: entry at r_mid arrives from memory this cycle
    assign probe_le = (CMP_W'(start_rdata) <= CMP_W'(r_off));
    assign lo_nx    = probe_le ? (LINE_W'(r_mid) + LINE_W'(1)) : r_lo;
    assign hi_nx    = probe_le ? r_hi : LINE_W'(r_mid);
    assign start_nx = probe_le ? start_rdata : r_lo_start;
    assign mid_nx   = ADDR_W'(lo_nx + ((hi_nx - lo_nx) >> 1));

    // line 0 or a line past the count
    assign span_bad = (i_query_line == '0) ||
                      (QCMP_W'(i_query_line) > QCMP_W'(r_lines));

    always_comb begin
        n_state     = r_state;
        n_lines     = r_lines;
        n_bytes     = r_bytes;
        n_prev_cr   = r_prev_cr;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_lo_start  = r_lo_start;
        n_off       = r_off;
        n_start     = r_start;
        n_end       = r_end;
        n_cr        = r_cr;
        n_res_line  = r_res_line;
        n_res_col   = r_res_col;
        n_res_start = r_res_start;
        n_res_len   = r_res_len;
        n_res_inv   = r_res_inv;
        mem_we      = 1'b0;
        rd_addr     = r_mid;
        out_load    = 1'b0;

        // result taken downstream
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_op'(i_operation))
                        OP_APPEND: begin
                            // bytes past the stream limit are dropped outright
                            if (r_bytes < BYTE_W'(MAX_BYTES)) begin
                                if (i_byte_value == NL_BYTE) begin
                                    if (r_lines < LINE_W'(MAX_LINES)) begin
                                        mem_we  = 1'b1;
                                        n_lines = r_lines + LINE_W'(1);
                                    end else begin
                                        n_ovf = 1'b1;
                                    end
                                end
                                n_prev_cr = (i_byte_value == CR_BYTE);
                                n_bytes   = r_bytes + BYTE_W'(1);
                            end
                        end
                        OP_LOCATE: begin
                            n_lo    = '0;
                            n_hi    = r_lines;
                            rd_addr = ADDR_W'(r_lines >> 1);
                            n_mid   = ADDR_W'(r_lines >> 1);
                            n_off   = i_query_offset;
                            n_state = S_LOC;
                        end
                        OP_SPAN: begin
                            n_res_line = '0;
                            n_res_col  = '0;
                            if (span_bad) begin
                                n_res_start = '0;
                                n_res_len   = '0;
                                n_res_inv   = 1'b1;
                                n_state     = S_OUT;
                            end else begin
                                rd_addr = ADDR_W'(i_query_line - QLN_W'(1));
                                n_mid   = ADDR_W'(i_query_line - QLN_W'(1));
                                n_state = S_SP1;
                            end
                        end
                        OP_CLEAR: begin
                            n_lines   = LINE_W'(1);
                            n_bytes   = '0;
                            n_prev_cr = 1'b0;
                            n_ovf     = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOC: begin
                n_lo       = lo_nx;
                n_hi       = hi_nx;
                n_lo_start = start_nx;
                if (lo_nx < hi_nx) begin
                    rd_addr = mid_nx;
                    n_mid   = mid_nx;
                end else begin
                    // start of the found line is the last entry that was not above the offset
                    n_res_line  = LNUM_W'(lo_nx);
                    n_res_col   = POS_W'(r_off) - POS_W'(start_nx) + POS_W'(1);
                    n_res_start = '0;
                    n_res_len   = '0;
                    n_res_inv   = 1'b0;
                    n_state     = S_OUT;
                end
            end
            S_SP1: begin
                n_start = start_rdata;
                n_cr    = cr_rdata;
                if ((LINE_W'(r_mid) + LINE_W'(1)) < r_lines) begin
                    rd_addr = r_mid + ADDR_W'(1);
                    n_state = S_SP2;
                end else begin
                    // last line ends at the stream end
                    n_end   = r_bytes;
                    n_cr    = r_prev_cr;
                    n_state = S_LEN;
                end
            end
            S_SP2: begin
                // next line start minus the newline
                n_end   = start_rdata - BYTE_W'(1);
                n_state = S_LEN;
            end
            S_LEN: begin
                n_res_start = POS_W'(r_start);
                // trailing cr only removed from a nonempty line
                n_res_len   = (r_end > r_start) ?
                              POS_W'(r_end - r_start - BYTE_W'(r_cr)) : '0;
                n_res_inv   = 1'b0;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lines     <= LINE_W'(1);
            r_bytes     <= '0;
            r_prev_cr   <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lines     <= n_lines;
            r_bytes     <= n_bytes;
            r_prev_cr   <= n_prev_cr;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_lo_start  <= n_lo_start;
        r_off       <= n_off;
        r_start     <= n_start;
        r_end       <= n_end;
        r_cr        <= n_cr;
        r_res_line  <= n_res_line;
        r_res_col   <= n_res_col;
        r_res_start <= n_res_start;
        r_res_len   <= n_res_len;
        r_res_inv   <= n_res_inv;
        if (out_load) begin
            r_o_line  <= r_res_line;
            r_o_col   <= r_res_col;
            r_o_start <= r_res_start;
            r_o_len   <= r_res_len;
            r_o_inv   <= r_res_inv;
            r_o_full  <= r_ovf;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_line_number   = r_o_line;
    assign o_column_number = r_o_col;
    assign o_span_start    = r_o_start;
    assign o_span_length   = r_o_len;
    assign o_span_invalid  = r_o_inv;
    assign o_table_full    = r_o_full;

    // line count stays within one and the table depth
    a_lines_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lines != '0) && (r_lines <= LINE_W'(MAX_LINES)))
        else $error("line count out of range");

    // stream length never passes its limit
    a_bytes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes <= BYTE_W'(MAX_BYTES))
        else $error("byte count past limit");

    // the search window is never empty while probing
    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOC) |-> ((r_lo < r_hi) && (LINE_W'(r_mid) < r_hi)))
        else $error("empty search window while probing");

    // a newline with room records exactly one line
    a_newline_records: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_operation == OP_APPEND) && (i_byte_value == NL_BYTE) &&
         (r_bytes < BYTE_W'(MAX_BYTES)) && (r_lines < LINE_W'(MAX_LINES)))
        |=> (r_lines == $past(r_lines) + LINE_W'(1)))
        else $error("newline did not record a line");

endmodule

[rtl/lil_table.sv]
// line start memory and trailing cr flag memory, one write and one read port each
// synchronous read; entry 0 of the start memory always reads as zero
// no package dependency

module lil_table #(
    parameter  int DEPTH  = 4096,
    parameter  int DATA_W = 17,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_start_waddr,
    input  logic [DATA_W-1:0] i_start_wdata,
    input  logic [ADDR_W-1:0] i_cr_waddr,
    input  logic              i_cr_wdata,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_start_rdata,
    output logic              o_cr_rdata
);

    logic [DATA_W-1:0] r_start_mem [DEPTH];
    logic              r_cr_mem    [DEPTH];
    logic [DATA_W-1:0] r_start_q;
    logic              r_cr_q;
    logic              r_rd_zero;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_start_mem[i_start_waddr] <= i_start_wdata;
            r_cr_mem[i_cr_waddr]       <= i_cr_wdata;
        end
        r_start_q <= r_start_mem[i_rd_addr];
        r_cr_q    <= r_cr_mem[i_rd_addr];
        r_rd_zero <= (i_rd_addr == '0);
    end

    // line 1 starts at offset 0; that entry is never written
    assign o_start_rdata = r_rd_zero ? '0 : r_start_q;
    assign o_cr_rdata    = r_cr_q;

endmodule
